### design/space_vector_pwm_timing_core_assert.svh
// ============================================================================
// Space vector PWM timing core: assertion macros
// Shorthand for the concurrent checks of the timing core. Each macro expects
// clk and rst_n to be visible where it is used.
// ============================================================================
`ifndef SPACE_VECTOR_PWM_TIMING_CORE_ASSERT_SVH
`define SPACE_VECTOR_PWM_TIMING_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVPWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SVPWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/svpwm_pkg.sv
// ============================================================================
// Space vector PWM timing package
// Fixed-point constants and the sector code type shared by the timing core.
// ============================================================================
package svpwm_pkg;

    // sqrt(3) in Q16 and its width.
    localparam int unsigned SQRT3_W   = 17;
    localparam logic [SQRT3_W-1:0] SQRT3_Q16 = 17'd113512;

    // The projected numerators carry 17 fractional bits against the bus voltage.
    localparam int unsigned FRAC_SHIFT = 17;

    // Reset value of the carrier period in timer counts.
    localparam int unsigned PERIOD_RESET = 1000;

    // Sector codes; the zero vector has a code of its own.
    typedef enum logic [2:0] {
        SEC_ZERO = 3'd0,
        SEC_1    = 3'd1,
        SEC_2    = 3'd2,
        SEC_3    = 3'd3,
        SEC_4    = 3'd4,
        SEC_5    = 3'd5,
        SEC_6    = 3'd6
    } sector_t;

endpackage

### design/svpwm_if.sv
// ============================================================================
// Space vector PWM timing channels
// Valid/ready channels for the voltage vector, the compare result and the
// carrier period register write.
// ============================================================================

// Voltage vector beat: alpha, beta and DC bus voltage.
interface svpwm_vec_if #(parameter int VOLT_WIDTH = 16) ();
    logic                         valid;
    logic                         ready;
    logic signed [VOLT_WIDTH-1:0] alpha_voltage;
    logic signed [VOLT_WIDTH-1:0] beta_voltage;
    logic        [VOLT_WIDTH-1:0] bus_voltage;

    modport source (output valid, output alpha_voltage, output beta_voltage,
                    output bus_voltage, input ready);
    modport sink   (input valid, input alpha_voltage, input beta_voltage,
                    input bus_voltage, output ready);
endinterface

// Compare result beat: sector, three compare values and the overmodulation flag.
interface svpwm_duty_if #(parameter int COUNT_WIDTH = 16) ();
    logic                   valid;
    logic                   ready;
    logic [2:0]             sector;
    logic [COUNT_WIDTH-1:0] phase_a_compare;
    logic [COUNT_WIDTH-1:0] phase_b_compare;
    logic [COUNT_WIDTH-1:0] phase_c_compare;
    logic                   overmodulated;

    modport source (output valid, output sector, output phase_a_compare,
                    output phase_b_compare, output phase_c_compare,
                    output overmodulated, input ready);
    modport sink   (input valid, input sector, input phase_a_compare,
                    input phase_b_compare, input phase_c_compare,
                    input overmodulated, output ready);
endinterface

// Carrier period register write beat.
interface svpwm_cfg_if #(parameter int COUNT_WIDTH = 16) ();
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] pwm_period;

    modport source (output valid, output pwm_period, input ready);
    modport sink   (input valid, input pwm_period, output ready);
endinterface

### design/space_vector_pwm_timing_core.sv
// ============================================================================
// Space vector PWM timing core
// Turns an alpha/beta voltage vector and the DC bus voltage into a sector
// code and three seven-segment compare values, with overmodulation limiting.
// ============================================================================
// Usage:
//   vec  (sink)   : one beat carries alpha_voltage, beta_voltage, bus_voltage.
//   duty (source) : one beat per vector with sector, the three phase compare
//                   values (0..pwm_period) and the overmodulated flag.
//   cfg  (sink)   : writes pwm_period; always ready. Write it only while no
//                   vector is in flight.
// One beat enters per cycle unless a duty stall has filled every stage; the
// pipelined restoring divider resolves one quotient bit per stage for both
// active times in parallel.
// Every stage holds a valid bit. When the duty receiver stalls, stages close
// up behind the output register, and vec.ready falls only once every stage is
// full; nothing is dropped or repeated.
// Reset empties the pipeline and sets pwm_period to 1000 counts.
// ============================================================================
`include "space_vector_pwm_timing_core_assert.svh"

module space_vector_pwm_timing_core #(
    parameter int VOLT_WIDTH  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    svpwm_vec_if.sink   vec,
    svpwm_duty_if.source duty,
    svpwm_cfg_if.sink   cfg
);
    import svpwm_pkg::*;

    localparam int VW   = VOLT_WIDTH;
    localparam int CW   = COUNT_WIDTH;
    // Signed width of the projected numerators.
    localparam int NW   = VW + 20;
    // Width of a clamped, non-negative numerator.
    localparam int UW   = NW - 1;
    // Width of the divider remainder, divisor and numerators.
    localparam int RW   = NW + 2;
    // Pipeline stage positions.
    localparam int P1S  = CW + 3;
    localparam int OUTS = CW + 4;
    localparam int NST  = CW + 5;

    localparam logic signed [SQRT3_W:0] SQRT3_S = {1'b0, SQRT3_Q16};

    typedef struct packed {
        logic signed [NW-1:0] a3;
        logic signed [NW-1:0] sb;
        logic                 b_pos;
        logic [VW-1:0]        udc;
    } s1_t;

    typedef struct packed {
        sector_t       sec;
        logic [UW-1:0] n1;
        logic [UW-1:0] n2;
        logic [VW-1:0] udc;
    } s2_t;

    typedef struct packed {
        logic [CW-1:0] q;
        logic [RW-1:0] r;
    } div_acc_t;

    typedef struct packed {
        sector_t       sec;
        logic          over;
        logic          dz;
        logic [RW-1:0] d;
        logic [RW-1:0] n1;
        logic [RW-1:0] n2;
        div_acc_t      acc1;
        div_acc_t      acc2;
    } div_stage_t;

    typedef struct packed {
        sector_t       sec;
        logic          over;
        logic [CW-1:0] t1;
        logic [CW-1:0] t2;
        logic [CW-1:0] t7;
    } p1_t;

    typedef struct packed {
        sector_t       sec;
        logic [CW-1:0] ca;
        logic [CW-1:0] cb;
        logic [CW-1:0] cc;
        logic          over;
    } out_t;

    // One restoring step of floor(n*t/d): shift in one period bit.
    function automatic div_acc_t div_step(div_acc_t acc, logic [RW-1:0] d,
                                          logic [RW-1:0] n, logic tb);
        div_acc_t o;
        o.q = acc.q << 1;
        o.r = acc.r << 1;
        if (o.r >= d)
        begin
            o.r = o.r - d;
            o.q = o.q + CW'(1);
        end
        if (tb)
        begin
            o.r = o.r + n;
            if (o.r >= d)
            begin
                o.r = o.r - d;
                o.q = o.q + CW'(1);
            end
        end
        return o;
    endfunction

    logic [CW-1:0]  pwm_period_reg;
    logic [CW-1:0]  pwm_period_next;
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] en;

    s1_t        s1_reg, s1_next;
    s2_t        s2_reg, s2_next;
    div_stage_t div_reg  [CW+1];
    div_stage_t div_next [CW+1];
    p1_t        p1_reg, p1_next;
    out_t       out_reg, out_next;

    // A stage may load when it is empty or its content moves on.
    assign en[NST-1] = !valid_reg[NST-1] || duty.ready;
    for (genvar k = 0; k < NST - 1; k++)
    begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    // Valid bits travel with the data.
    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = vec.valid;
        end
        for (int k = 1; k < NST; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    // Carrier period register.
    always_comb
    begin
        pwm_period_next = pwm_period_reg;
        if (cfg.valid)
        begin
            pwm_period_next = cfg.pwm_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            pwm_period_reg <= CW'(PERIOD_RESET);
        end
        else
        begin
            valid_reg      <= valid_next;
            pwm_period_reg <= pwm_period_next;
        end
    end

    // Stage 1: scale alpha by 3*2^16 and beta by sqrt(3).
    always_comb
    begin
        logic signed [NW-1:0] a_x;
        logic signed [NW-1:0] b_x;
        a_x = NW'(vec.alpha_voltage);
        b_x = NW'(vec.beta_voltage);
        s1_next.a3    = (a_x + (a_x <<< 1)) <<< 16;
        s1_next.sb    = b_x * NW'(SQRT3_S);
        s1_next.b_pos = !vec.beta_voltage[VW-1] && (vec.beta_voltage != '0);
        s1_next.udc   = vec.bus_voltage;
    end

    // Stage 2: projected references, sector and active vector numerators.
    always_comb
    begin
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic signed [NW-1:0] s1v;
        logic signed [NW-1:0] s2v;
        logic [2:0]           sbits;
        nx    = s1_reg.sb <<< 1;
        ny    = s1_reg.a3 - s1_reg.sb;
        nz    = -s1_reg.a3 - s1_reg.sb;
        sbits = {!nz[NW-1] && (nz != '0), !ny[NW-1] && (ny != '0), s1_reg.b_pos};
        case (sbits)
            SEC_1:   begin s1v = -ny; s2v = -nz; end
            SEC_2:   begin s1v = -nz; s2v = -nx; end
            SEC_3:   begin s1v = ny;  s2v = nx;  end
            SEC_4:   begin s1v = -nx; s2v = -ny; end
            SEC_5:   begin s1v = nx;  s2v = nz;  end
            SEC_6:   begin s1v = nz;  s2v = ny;  end
            default: begin s1v = '0;  s2v = '0;  end
        endcase
        if (sbits == 3'b111)
        begin
            s2_next.sec = SEC_ZERO;
        end
        else
        begin
            s2_next.sec = sector_t'(sbits);
        end
        s2_next.n1  = s1v[NW-1] ? '0 : s1v[UW-1:0];
        s2_next.n2  = s2v[NW-1] ? '0 : s2v[UW-1:0];
        s2_next.udc = s1_reg.udc;
    end

    // Stage 3: pick the divisor, bus voltage or the active sum when it overflows.
    always_comb
    begin
        logic [RW-1:0] sum;
        logic [RW-1:0] dd;
        sum = RW'(s2_reg.n1) + RW'(s2_reg.n2);
        dd  = RW'(s2_reg.udc) << FRAC_SHIFT;
        div_next[0].sec  = s2_reg.sec;
        div_next[0].over = sum > dd;
        div_next[0].d    = (sum > dd) ? sum : dd;
        div_next[0].dz   = (sum <= dd) && (dd == '0);
        div_next[0].n1   = RW'(s2_reg.n1);
        div_next[0].n2   = RW'(s2_reg.n2);
        div_next[0].acc1 = '0;
        div_next[0].acc2 = '0;
    end

    // Divider stages: one period bit per stage, most significant first.
    for (genvar j = 1; j <= CW; j++)
    begin : g_div
        always_comb
        begin
            div_next[j]      = div_reg[j-1];
            div_next[j].acc1 = div_step(div_reg[j-1].acc1, div_reg[j-1].d,
                                        div_reg[j-1].n1, pwm_period_reg[CW-j]);
            div_next[j].acc2 = div_step(div_reg[j-1].acc2, div_reg[j-1].d,
                                        div_reg[j-1].n2, pwm_period_reg[CW-j]);
        end
    end

    // Post stage 1: active times and the half zero time.
    always_comb
    begin
        logic [CW:0] sum12;
        p1_next.sec  = div_reg[CW].sec;
        p1_next.over = div_reg[CW].over;
        p1_next.t1   = div_reg[CW].dz ? '0 : div_reg[CW].acc1.q;
        p1_next.t2   = div_reg[CW].dz ? '0 : div_reg[CW].acc2.q;
        sum12        = (CW+1)'(p1_next.t1) + (CW+1)'(p1_next.t2);
        if (sum12 > (CW+1)'(pwm_period_reg))
        begin
            p1_next.t7 = '0;
        end
        else
        begin
            p1_next.t7 = CW'(((CW+1)'(pwm_period_reg) - sum12) >> 1);
        end
    end

    // Post stage 2: seven-segment compare table, clamped to the period.
    always_comb
    begin
        logic [CW+1:0] tp;
        logic [CW+1:0] lo;
        logic [CW+1:0] mid;
        logic [CW+1:0] hi;
        logic [CW-1:0] lo_c;
        logic [CW-1:0] mid_c;
        logic [CW-1:0] hi_c;
        tp    = (CW+2)'(pwm_period_reg);
        lo    = (CW+2)'(p1_reg.t7);
        mid   = (CW+2)'(p1_reg.t2) + lo;
        hi    = (CW+2)'(p1_reg.t1) + mid;
        lo_c  = (lo  > tp) ? pwm_period_reg : lo[CW-1:0];
        mid_c = (mid > tp) ? pwm_period_reg : mid[CW-1:0];
        hi_c  = (hi  > tp) ? pwm_period_reg : hi[CW-1:0];
        out_next.sec  = p1_reg.sec;
        out_next.over = p1_reg.over;
        case (p1_reg.sec)
            SEC_ZERO:
            begin
                out_next.ca   = pwm_period_reg >> 1;
                out_next.cb   = pwm_period_reg >> 1;
                out_next.cc   = pwm_period_reg >> 1;
                out_next.over = 1'b0;
            end
            SEC_1:   begin out_next.ca = mid_c; out_next.cb = hi_c;  out_next.cc = lo_c;  end
            SEC_2:   begin out_next.ca = hi_c;  out_next.cb = lo_c;  out_next.cc = mid_c; end
            SEC_3:   begin out_next.ca = hi_c;  out_next.cb = mid_c; out_next.cc = lo_c;  end
            SEC_4:   begin out_next.ca = lo_c;  out_next.cb = mid_c; out_next.cc = hi_c;  end
            SEC_5:   begin out_next.ca = lo_c;  out_next.cb = hi_c;  out_next.cc = mid_c; end
            default: begin out_next.ca = mid_c; out_next.cb = lo_c;  out_next.cc = hi_c;  end
        endcase
    end

    // Payload registers load whenever their stage may load.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= s1_next;
        end
        if (en[1])
        begin
            s2_reg <= s2_next;
        end
        if (en[P1S])
        begin
            p1_reg <= p1_next;
        end
        if (en[OUTS])
        begin
            out_reg <= out_next;
        end
    end

    for (genvar j = 0; j <= CW; j++)
    begin : g_div_reg
        always_ff @(posedge clk)
        begin
            if (en[2+j])
            begin
                div_reg[j] <= div_next[j];
            end
        end
    end

    // Channel outputs.
    assign vec.ready            = en[0];
    assign cfg.ready            = 1'b1;
    assign duty.valid           = valid_reg[OUTS];
    assign duty.sector          = out_reg.sec;
    assign duty.phase_a_compare = out_reg.ca;
    assign duty.phase_b_compare = out_reg.cb;
    assign duty.phase_c_compare = out_reg.cc;
    assign duty.overmodulated   = out_reg.over;

    // Checks.
    `SVPWM_ASSERT_SAME(a_zero_sector, valid_reg[OUTS] && (out_reg.sec == SEC_ZERO), !out_reg.over && (out_reg.ca == out_reg.cb) && (out_reg.cb == out_reg.cc), "zero vector beat must have equal compares and no overmodulation")
    `SVPWM_ASSERT_SAME(a_compare_bound, valid_reg[OUTS], (out_reg.ca <= pwm_period_reg) && (out_reg.cb <= pwm_period_reg) && (out_reg.cc <= pwm_period_reg), "compare value above the carrier period")
    `SVPWM_ASSERT_SAME(a_over_no_zero_time, valid_reg[P1S] && p1_reg.over && (p1_reg.sec != SEC_ZERO), p1_reg.t7 == '0, "overmodulated vector left zero time")
    `SVPWM_ASSERT_SAME(a_stall_only_when_full, !en[0], &valid_reg, "input stalled while a pipeline stage is empty")
    `SVPWM_ASSERT_NEXT(a_output_load, valid_reg[P1S] && en[OUTS], valid_reg[OUTS], "beat lost between the last two stages")

endmodule
